// File: rtl/multichannel_moving_average_assert.svh
// assertion macros for the rtl files that include this header
// both macros use the enclosing module's clk and rst_n
`ifndef MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define MMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Payload types and register map of the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

    // fixed field widths
    localparam int CHANNEL_W  = 4;
    localparam int SAMPLE_W   = 12;
    localparam int WIN_LEN_W  = 5;
    localparam int MASK_W     = 16;
    localparam int ACTIVE_W   = 5;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] REG_ENABLE_MASK   = 2'd1;
    localparam logic [1:0] REG_ACTIVE_CHANS  = 2'd2;

    // reset values
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 5'd1;
    localparam logic [MASK_W-1:0]    MASK_RESET    = 16'd0;
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 5'd16;

    // input item
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [SAMPLE_W-1:0]  value;
        logic                 filtered;
    } out_item_t;

endpackage

// File: rtl/mma_ring.sv
// ----------------------------------------------------------------------------
// mma_ring
// Sample ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mma_ring #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/mma_div.sv
// ----------------------------------------------------------------------------
// mma_div
// Restoring divider, one quotient bit per cycle, NUM_W-bit quotient.
// ----------------------------------------------------------------------------
module mma_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/multichannel_moving_average.sv
// Timing: a raw pass-through item goes from ST_IDLE to ST_DONE, and its result
// is loaded into the result register once that register is free; an averaged
// item passes ST_WRITE, the ST_READ window walk over w entries, ST_DRAIN,
// ST_START and ST_DIV before ST_DONE, w being the window length.
// Throughput: one item at a time, the next accepted in the cycle after the result
// is loaded; the ring walk (one read per cycle) and the serial divider set it.
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel boxcar average of scanned converter samples, with an apb port
// for window length, enable mask and active channel count.
// Reset: a clearing pass over all CHANNELS*WINDOW_MAX ring entries zeroes the rings first.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_assert.svh"

module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_item_t              item,
    // result items
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_item_t             result,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = CHANNELS * WINDOW_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CUR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_BITS + WCNT_W;
    localparam int KEEP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_WRITE = 8'b0000_0100,
        ST_READ  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_START = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;

    logic [WIN_LEN_W-1:0]   win_len_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [ACTIVE_W-1:0]    active_reg;

    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [WCNT_W-1:0]      k_reg;
    logic                   rd_pend_reg;
    logic [SUM_W-1:0]       acc_reg;

    logic [CHANNEL_W-1:0]   chan_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   filt_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [ADDR_W-1:0]      wr_addr_reg;

    logic                   result_valid_reg;
    out_item_t              result_reg;

    logic [WCNT_W-1:0]      eff_win;
    logic [ACTIVE_W-1:0]    last_chan;
    logic [WCNT_W-1:0]      cur_inc;
    logic                   in_xfer;
    logic                   out_xfer;
    logic                   cfg_wr;
    logic                   chan_ok;
    logic                   filt_in;
    logic                   is_last;
    logic [SAMPLE_BITS-1:0] smp_in;
    logic                   load_result;

    logic                   ring_we;
    logic [ADDR_W-1:0]      ring_waddr;
    logic [SAMPLE_BITS-1:0] ring_wdata;
    logic                   ring_re;
    logic [ADDR_W-1:0]      ring_raddr;
    logic [SAMPLE_BITS-1:0] ring_rdata;

    logic                   div_start;
    logic                   div_busy;
    logic [SUM_W-1:0]       div_quo;

    // handshakes
    assign in_xfer     = item_valid && !item_stall;
    assign out_xfer    = result_valid_reg && !result_stall;
    assign item_stall  = (state_reg != ST_IDLE);
    assign load_result = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    // apb register writes
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WIN_LEN_RESET;
            mask_reg    <= MASK_RESET;
            active_reg  <= ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WINDOW_LENGTH: win_len_reg <= pwdata[WIN_LEN_W-1:0];
                REG_ENABLE_MASK:   mask_reg    <= pwdata[MASK_W-1:0];
                REG_ACTIVE_CHANS:  active_reg  <= pwdata[ACTIVE_W-1:0];
                default:           ;
            endcase
        end
    end

    // apb register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(win_len_reg);
            REG_ENABLE_MASK:   prdata = APB_DATA_W'(mask_reg);
            REG_ACTIVE_CHANS:  prdata = APB_DATA_W'(active_reg);
            default:           prdata = '0;
        endcase
    end

    // effective window length, 1..WINDOW_MAX
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            eff_win = WCNT_W'(1);
        end
        else if (32'(win_len_reg) > 32'(WINDOW_MAX))
        begin
            eff_win = WCNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_win = WCNT_W'(win_len_reg);
        end
    end

    // last channel of a scan
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_chan = '0;
        end
        else if (32'(active_reg) > 32'(CHANNELS))
        begin
            last_chan = ACTIVE_W'(CHANNELS - 1);
        end
        else
        begin
            last_chan = active_reg - ACTIVE_W'(1);
        end
    end

    // input decode
    assign chan_ok = (32'(item.channel) < 32'(CHANNELS));
    assign filt_in = chan_ok && mask_reg[item.channel];
    assign is_last = (ACTIVE_W'(item.channel) == last_chan);
    assign smp_in  = SAMPLE_BITS'(item.sample[KEEP_W-1:0]);

    // shared cursor advance with wrap at the window length
    always_comb
    begin
        cur_inc = WCNT_W'(cursor_reg) + WCNT_W'(1);
        if (cur_inc >= eff_win)
        begin
            cursor_next = '0;
        end
        else
        begin
            cursor_next = CUR_W'(cur_inc);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = filt_in ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_READ;
            ST_READ:
            begin
                if (k_reg == eff_win - WCNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cursor_reg       <= '0;
            clr_cnt_reg      <= '0;
            k_reg            <= '0;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (in_xfer && is_last)
            begin
                cursor_reg <= cursor_next;
            end
            if (state_reg == ST_WRITE)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                k_reg <= k_reg + WCNT_W'(1);
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and accumulator
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            chan_reg    <= item.channel;
            smp_reg     <= smp_in;
            filt_reg    <= filt_in;
            base_reg    <= ADDR_W'(item.channel) * ADDR_W'(WINDOW_MAX);
            wr_addr_reg <= ADDR_W'(item.channel) * ADDR_W'(WINDOW_MAX)
                           + ADDR_W'(cursor_reg);
        end
        if (state_reg == ST_WRITE)
        begin
            acc_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(ring_rdata);
        end
        if (load_result)
        begin
            result_reg.out_channel <= chan_reg;
            result_reg.filtered    <= filt_reg;
            result_reg.value       <= filt_reg ? SAMPLE_W'(div_quo[KEEP_W-1:0])
                                               : SAMPLE_W'(smp_reg[KEEP_W-1:0]);
        end
    end

    // ring ports: clearing pass or sample write, window walk reads
    assign ring_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign ring_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wr_addr_reg;
    assign ring_wdata = (state_reg == ST_CLEAR) ? '0 : smp_reg;
    assign ring_re    = (state_reg == ST_READ);
    assign ring_raddr = base_reg + ADDR_W'(k_reg);

    mma_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // window sum divided by the window length
    assign div_start = (state_reg == ST_START);

    mma_div #(
        .NUM_W (SUM_W),
        .DEN_W (WCNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (acc_reg),
        .denom    (eff_win),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `MMA_ASSERT_NEXT(a_transfer_leaves_idle, in_xfer, state_reg != ST_IDLE,
        "input transfer did not start item processing")
    `MMA_ASSERT_NOW(a_cursor_in_range, 1'b1, 32'(cursor_reg) < 32'(WINDOW_MAX),
        "window cursor beyond ring depth")
    `MMA_ASSERT_NOW(a_div_busy_in_div, div_busy, state_reg == ST_DIV,
        "divider running outside the divide step")

endmodule

// File: dv/tb_multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// tb_multichannel_moving_average
// Self-checking bench for the per-channel boxcar average. Samples go in over
// the valid/stall channel, registers are set over apb between phases, and a
// scoreboard keeps its own rings and cursor to predict each result. Both
// sides idle in random bursts, and the result side holds off for a long
// stretch once so that the block backs up.
// ----------------------------------------------------------------------------

// predicts averages from its own copy of the rings and checks the results
class avg_scoreboard;
    localparam int NUM_CH   = 16;
    localparam int RING_LEN = 16;

    logic [mma_pkg::SAMPLE_W-1:0]  ring [NUM_CH][RING_LEN];
    int unsigned                   cursor;
    logic [mma_pkg::WIN_LEN_W-1:0] win_len_reg;
    logic [mma_pkg::MASK_W-1:0]    mask_reg;
    logic [mma_pkg::ACTIVE_W-1:0]  active_reg;
    mma_pkg::out_item_t            expected_out[$];
    int unsigned                   errors;
    int unsigned                   samples_seen;
    int unsigned                   averages_seen;

    function new();
        foreach (ring[c, k])
            ring[c][k] = '0;
        cursor        = 0;
        win_len_reg   = mma_pkg::WIN_LEN_RESET;
        mask_reg      = mma_pkg::MASK_RESET;
        active_reg    = mma_pkg::ACTIVE_RESET;
        errors        = 0;
        samples_seen  = 0;
        averages_seen = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
        case (index)
            mma_pkg::REG_WINDOW_LENGTH: win_len_reg = data[mma_pkg::WIN_LEN_W-1:0];
            mma_pkg::REG_ENABLE_MASK:   mask_reg    = data[mma_pkg::MASK_W-1:0];
            mma_pkg::REG_ACTIVE_CHANS:  active_reg  = data[mma_pkg::ACTIVE_W-1:0];
            default: ;
        endcase
    endfunction

    // window length clamped to 1..RING_LEN
    function int unsigned eff_window();
        if (win_len_reg == 0)
            return 1;
        if (win_len_reg > RING_LEN)
            return RING_LEN;
        return win_len_reg;
    endfunction

    // scan length clamped to 1..NUM_CH
    function int unsigned eff_active();
        if (active_reg == 0)
            return 1;
        if (active_reg > NUM_CH)
            return NUM_CH;
        return active_reg;
    endfunction

    function mma_pkg::out_item_t predict_average(mma_pkg::in_item_t it);
        mma_pkg::out_item_t o;
        int unsigned        w;
        int unsigned        sum;
        int unsigned        avg;
        int unsigned        k;
        w             = eff_window();
        o.out_channel = it.channel;
        o.value       = it.sample;
        o.filtered    = 1'b0;
        // store at the shared cursor, then sum the leading window entries
        if (mask_reg[it.channel])
        begin
            ring[it.channel][cursor] = it.sample;
            sum = 0;
            for (k = 0; k < w; k++)
                sum += ring[it.channel][k];
            avg        = sum / w;
            o.value    = avg[mma_pkg::SAMPLE_W-1:0];
            o.filtered = 1'b1;
        end
        // cursor moves after the last channel of the scan
        if (it.channel == eff_active() - 1)
        begin
            cursor++;
            if (cursor >= w)
                cursor = 0;
        end
        return o;
    endfunction

    function void note_sample(mma_pkg::in_item_t it);
        mma_pkg::out_item_t o;
        o = predict_average(it);
        samples_seen++;
        if (o.filtered)
            averages_seen++;
        expected_out.push_back(o);
    endfunction

    function void check_output(mma_pkg::out_item_t got);
        mma_pkg::out_item_t want;
        if (expected_out.size() == 0)
        begin
            errors++;
            $display("%0t ERROR unexpected result: ch %0d value %0d filtered %0b",
                     $time, got.out_channel, got.value, got.filtered);
            return;
        end
        want = expected_out.pop_front();
        if (got.out_channel !== want.out_channel)
        begin
            errors++;
            $display("%0t ERROR out_channel: expected %0d actual %0d",
                     $time, want.out_channel, got.out_channel);
        end
        if (got.value !== want.value)
        begin
            errors++;
            $display("%0t ERROR value (ch %0d): expected %0d actual %0d",
                     $time, want.out_channel, want.value, got.value);
        end
        if (got.filtered !== want.filtered)
        begin
            errors++;
            $display("%0t ERROR filtered (ch %0d): expected %0b actual %0b",
                     $time, want.out_channel, want.filtered, got.filtered);
        end
    endfunction
endclass

module tb_multichannel_moving_average
    import mma_pkg::*;
();

    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_stall;
    out_item_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    avg_scoreboard sb;
    bit            idle_on;
    bit            long_hold;
    int unsigned   settings_count;

    multichannel_moving_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result transfers go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_output(result);
    end

    // result side: long hold-off on request, else, while idling is on, short random stall bursts
    initial
    begin : result_receiver
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_sample(logic [CHANNEL_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
        in_item_t it;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        it.channel = ch;
        it.sample  = smp;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_sample(it);
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_out.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] index, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(index, data);
    endtask

    task automatic configure(int unsigned win, int unsigned mask, int unsigned act);
        wait_drain();
        apb_write(REG_WINDOW_LENGTH, win);
        apb_write(REG_ENABLE_MASK, mask);
        apb_write(REG_ACTIVE_CHANS, act);
        settings_count++;
    endtask

    // mostly in-order scans with random samples, some stray channels
    task automatic run_scan(int n);
        int          k;
        int unsigned pos;
        pos = 0;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(CHANNEL_W'($urandom_range(0, 15)), rand_sample());
            else
            begin
                send_sample(CHANNEL_W'(pos), rand_sample());
                pos = (pos + 1) % sb.eff_active();
            end
        end
    endtask

    initial
    begin : stimulus
        int          p;
        int          k;
        int unsigned win;
        int unsigned mask;
        int unsigned act;
        sb             = new();
        idle_on        = 1'b0;
        long_hold      = 1'b0;
        settings_count = 0;
        rst_n          <= 1'b0;
        item_valid     <= 1'b0;
        item           <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: everything passes through raw
        send_sample(4'd0, 12'h000);
        send_sample(4'd15, 12'hFFF);
        send_sample(4'd5, 12'hAAA);
        send_sample(4'd10, 12'h555);

        // all channels averaged over 4, two-channel scan; rings start at zero
        configure(4, 16'hFFFF, 2);
        send_sample(4'd0, 12'hFFF);
        send_sample(4'd1, 12'hFFF);
        send_sample(4'd0, 12'hFFF);
        send_sample(4'd1, 12'h000);
        send_sample(4'd15, 12'hFFF);
        send_sample(4'd0, 12'hFFF);
        send_sample(4'd1, 12'hFFF);

        // zero window and zero scan length both act as one
        configure(0, 16'h8001, 0);
        send_sample(4'd0, 12'd100);
        send_sample(4'd15, 12'hFFF);
        send_sample(4'd7, 12'd1234);

        // oversized window and scan length saturate
        configure(31, 16'hFFFF, 31);
        send_sample(4'd15, 12'hFFF);
        send_sample(4'd3, 12'd7);

        // walk the cursor far out, then shrink the window under it
        configure(16, 16'h0001, 1);
        for (k = 0; k < 6; k++)
            send_sample(4'd0, rand_sample());
        configure(4, 16'h0001, 1);
        for (k = 0; k < 3; k++)
            send_sample(4'd0, rand_sample());

        // eight phases, the first three fixed and the rest random; phases 2, 4, 6 and 7 run without idling
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: configure(16, 16'hFFFF, 16);
                1: configure(1, 16'h0000, 1);
                2: configure(8, 16'h00FF, 5);
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       win = 0;
                        1:       win = $urandom_range(17, 31);
                        default: win = $urandom_range(1, 16);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       mask = 16'h0000;
                        1:       mask = 16'hFFFF;
                        default: mask = $urandom_range(0, 65535);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       act = 0;
                        1:       act = $urandom_range(17, 31);
                        default: act = $urandom_range(1, 16);
                    endcase
                    configure(win, mask, act);
                end
            endcase
            idle_on = (p < 6) && (p != 2) && (p != 4);
            // result side blocks for a while, sender keeps pushing
            if (p == 2)
                long_hold = 1'b1;
            run_scan(110);
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d samples, %0d of them averaged, over %0d register settings",
                 sb.samples_seen, sb.averages_seen, settings_count);
        $display("settings included zero and oversized window and scan lengths");
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #500000;
        $display("timeout waiting for transfers");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
